// ===== sv/pwd_pkg.sv =====
// Shared types and constants for the pairwise Euclidean distance unit.
// Holds the transfer payload structs, command and register codes and datapath widths.
// No dependencies.
package pwd_pkg;

   // Field and datapath widths.
   localparam int COORD_BITS       = 24;
   localparam int FRAC_BITS        = 8;
   localparam int PT_W             = 10;
   localparam int DIST_W           = 17;
   localparam int NC_W             = 11;
   localparam int SQ_W             = 2 * COORD_BITS;
   localparam int SUM_W            = SQ_W + 2;
   localparam int V_W              = SUM_W - 2 * FRAC_BITS;
   localparam int ROOT_BITS        = (V_W + 1) / 2;

   // Defaults and sizes.
   localparam int DEF_MAX_NODES    = 1024;
   localparam int NODE_COUNT_RESET = 1024;
   localparam int RSPQ_DEPTH       = 32;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 16;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef enum logic [0:0] {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THREE_D    = 2'd0,
      CSR_NODE_COUNT = 2'd1
   } csr_idx_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      cmd_type         cmd;
      logic [PT_W-1:0] point_a;
      logic [PT_W-1:0] point_b;
      coord_type       x_coord;
      coord_type       y_coord;
      coord_type       z_coord;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              index_error;
   } rsp_type;

   // Per-query control that rides along the pipeline.
   typedef struct packed {
      logic err;
      logic zero;
   } ctl_type;

endpackage

// ===== sv/pwd_store.sv =====
// Coordinate store: one synchronous memory of points, one write port, two read ports.
// Read data is registered.
// Depends on pwd_pkg.
module pwd_store import pwd_pkg::*; #(
   parameter int DEPTH = DEF_MAX_NODES
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  point_type                wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output point_type                rd_data_a,
   output point_type                rd_data_b
);

   point_type mem [DEPTH];

   // A load writes at the edge of its transfer; any later query reads the new entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== sv/pwd_sqsum.sv =====
// Difference, square and sum stages: turns two points into the sum of squared
// differences with the fraction bits of the square dropped. Three register stages.
// Depends on pwd_pkg.
module pwd_sqsum import pwd_pkg::*; (
   input  logic           clock,
   input  point_type      pt_a,
   input  point_type      pt_b,
   input  logic           three_d,
   output logic [V_W-1:0] sum_sq
);

   logic [COORD_BITS-1:0] dx_ff, dy_ff, dz_ff;
   logic [SQ_W-1:0]       sqx_ff, sqy_ff, sqz_ff;
   logic [SUM_W-1:0]      total;
   logic [V_W-1:0]        sum_ff;

   // Magnitude of the difference of two signed coordinates.
   function automatic logic [COORD_BITS-1:0] magnitude(coord_type a, coord_type b);
      logic [COORD_BITS:0] d;
      begin
         d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
         magnitude = d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
      end
   endfunction

   // Stage one: absolute differences, z forced to zero in 2D mode.
   always_ff @(posedge clock) begin
      dx_ff <= magnitude(pt_a.x, pt_b.x);
      dy_ff <= magnitude(pt_a.y, pt_b.y);
      dz_ff <= three_d ? magnitude(pt_a.z, pt_b.z) : '0;
   end

   // Stage two: one multiplier per axis.
   always_ff @(posedge clock) begin
      sqx_ff <= dx_ff * dx_ff;
      sqy_ff <= dy_ff * dy_ff;
      sqz_ff <= dz_ff * dz_ff;
   end

   // Stage three: sum and drop the fraction bits of the squared value.
   assign total = SUM_W'(sqx_ff) + SUM_W'(sqy_ff) + SUM_W'(sqz_ff);

   always_ff @(posedge clock) begin
      sum_ff <= total[SUM_W-1:2*FRAC_BITS];
   end

   assign sum_sq = sum_ff;

endmodule

// ===== sv/pwd_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, restoring method.
// Takes a new operand every cycle.
// Depends on pwd_pkg.
module pwd_isqrt import pwd_pkg::*; (
   input  logic                 clock,
   input  logic [V_W-1:0]       radicand,
   output logic [ROOT_BITS-1:0] root
);

   localparam int RW    = ROOT_BITS + 2;
   localparam int TW    = RW + 2;
   localparam int VP_W  = 2 * ROOT_BITS;

   logic [RW-1:0]        rem_ff [ROOT_BITS-1];
   logic [VP_W-1:0]      vs_ff  [ROOT_BITS-1];
   logic [ROOT_BITS-1:0] q_ff   [ROOT_BITS];

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      logic [RW-1:0]        rem_p;
      logic [ROOT_BITS-1:0] q_p;
      logic [VP_W-1:0]      vs_p;
      logic [TW-1:0]        rem_t;
      logic [TW-1:0]        trial;
      logic                 ge;

      // First stage starts from an empty remainder and the padded operand.
      if (k == 0) begin : g_first
         assign rem_p = '0;
         assign q_p   = '0;
         assign vs_p  = VP_W'(radicand);
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign q_p   = q_ff[k-1];
         assign vs_p  = vs_ff[k-1];
      end

      // Bring down the next two bits and try to subtract 4q+1.
      assign rem_t = {rem_p, vs_p[VP_W-1 -: 2]};
      assign trial = TW'({q_p, 2'b01});
      assign ge    = rem_t >= trial;

      always_ff @(posedge clock) begin
         q_ff[k] <= {q_p[ROOT_BITS-2:0], ge};
      end

      // The last stage only needs the root.
      if (k < ROOT_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k] <= ge ? RW'(rem_t - trial) : RW'(rem_t);
            vs_ff[k]  <= vs_p << 2;
         end
      end
   end

   assign root = q_ff[ROOT_BITS-1];

endmodule

// ===== sv/pwd_rspq.sv =====
// Result queue between the compute pipeline and the result channel.
// Small register FIFO; the caller guarantees it never overflows.
// Depends on pwd_pkg.
module pwd_rspq import pwd_pkg::*; #(
   parameter int DEPTH = RSPQ_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   input  logic    pop,
   output logic    out_valid,
   output rsp_type out_data
);

   localparam int PTR_W = $clog2(DEPTH);

   rsp_type              entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]       count_ff;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];

endmodule

// ===== sv/pairwise_euclidean_distance.sv =====
// Pairwise Euclidean distance unit. A load transfer writes a point's x, y and z
// (signed Q16.8) into the coordinate store and completes at its transfer; it gives
// no result. A query transfer names two points and yields one result: the floor of
// their distance in whole units (z ignored unless three_d is set), or 0 with
// index_error set when either index is at or above node_count. One item can be taken
// every cycle while the request channel does not stall. The store is read at the
// transfer edge itself; the difference, square and sum registers follow, then the
// pipelined square root, one root bit per stage, and last the write into the result
// queue. Up to 32 queries may be outstanding, set by the result queue; with 32 queries
// not yet delivered the request channel stalls. Points must be loaded before they are
// queried; the store is not cleared at reset.
// Depends on pwd_pkg, pwd_store, pwd_sqsum, pwd_isqrt and pwd_rspq.
module pairwise_euclidean_distance import pwd_pkg::*; #(
   parameter int MAX_NODES = DEF_MAX_NODES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_NODES);
   localparam int EXT_W  = (ADDR_W > PT_W) ? ADDR_W : PT_W;
   localparam int NST    = 4 + ROOT_BITS;
   localparam int CNT_W  = $clog2(RSPQ_DEPTH) + 1;

   logic                 req_xfer, rsp_xfer, query_xfer, load_xfer;
   logic [EXT_W-1:0]     a_ext, b_ext;
   logic                 a_in_max, b_in_max, a_in_cnt, b_in_cnt;
   ctl_type              ctl_new;
   point_type            wr_point, pt_a, pt_b;
   logic [V_W-1:0]       sum_sq;
   logic [ROOT_BITS-1:0] root;
   rsp_type              push_data;

   logic                 three_d_ff;
   logic [NC_W-1:0]      node_count_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [NST-1:0]       v_ff;
   ctl_type              ctl_ff [NST];

   // Transfers on the three channels.
   assign req_xfer   = req_valid && !req_stall;
   assign rsp_xfer   = rsp_valid && !rsp_stall;
   assign query_xfer = req_xfer && (req_data.cmd == CMD_QUERY);
   assign load_xfer  = req_xfer && (req_data.cmd == CMD_LOAD);
   assign csr_ready  = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         three_d_ff    <= 1'b0;
         node_count_ff <= NC_W'(NODE_COUNT_RESET);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_THREE_D:    three_d_ff    <= csr_wdata[0];
            CSR_NODE_COUNT: node_count_ff <= csr_wdata[NC_W-1:0];
            default:        ;
         endcase
      end
   end

   // Index checks against the store depth and the configured point count.
   assign a_ext    = EXT_W'(req_data.point_a);
   assign b_ext    = EXT_W'(req_data.point_b);
   assign a_in_max = {1'b0, a_ext} < (EXT_W + 1)'(MAX_NODES);
   assign b_in_max = {1'b0, b_ext} < (EXT_W + 1)'(MAX_NODES);
   assign a_in_cnt = {1'b0, req_data.point_a} < node_count_ff;
   assign b_in_cnt = {1'b0, req_data.point_b} < node_count_ff;

   always_comb begin
      ctl_new.err  = !(a_in_max && b_in_max && a_in_cnt && b_in_cnt);
      ctl_new.zero = ctl_new.err || (req_data.point_a == req_data.point_b);
   end

   // Coordinate store; loads beyond the store depth are dropped.
   assign wr_point = '{x: req_data.x_coord, y: req_data.y_coord, z: req_data.z_coord};

   pwd_store #(
      .DEPTH (MAX_NODES)
   ) u_store (
      .clock     (clock),
      .wr_en     (load_xfer && a_in_max),
      .wr_addr   (a_ext[ADDR_W-1:0]),
      .wr_data   (wr_point),
      .rd_addr_a (a_ext[ADDR_W-1:0]),
      .rd_addr_b (b_ext[ADDR_W-1:0]),
      .rd_data_a (pt_a),
      .rd_data_b (pt_b)
   );

   pwd_sqsum u_sqsum (
      .clock   (clock),
      .pt_a    (pt_a),
      .pt_b    (pt_b),
      .three_d (three_d_ff),
      .sum_sq  (sum_sq)
   );

   pwd_isqrt u_isqrt (
      .clock    (clock),
      .radicand (sum_sq),
      .root     (root)
   );

   // Query valid bits along the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[NST-2:0], query_xfer};
      end
   end

   // Control flags follow their query through every stage.
   always_ff @(posedge clock) begin
      ctl_ff[0] <= ctl_new;
      for (int i = 1; i < NST; i++) begin
         ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   // Result assembly at the end of the root pipeline.
   always_comb begin
      push_data.distance    = ctl_ff[NST-1].zero ? '0 : DIST_W'(root);
      push_data.index_error = ctl_ff[NST-1].err;
   end

   pwd_rspq #(
      .DEPTH (RSPQ_DEPTH)
   ) u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (v_ff[NST-1]),
      .push_data (push_data),
      .pop       (rsp_xfer),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   // Outstanding query count: in the pipeline or waiting in the result queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         case ({query_xfer, rsp_xfer})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   assign req_stall = cnt_ff == CNT_W'(RSPQ_DEPTH);

   // Checks on the credit scheme and the result path.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(RSPQ_DEPTH))
      else $error("outstanding query count above result queue depth");

   a_rsp_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != '0)
      else $error("result offered with no outstanding query");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.index_error |-> rsp_data.distance == '0)
      else $error("flagged result carries a nonzero distance");

   a_query_enters: assert property (@(posedge clock) disable iff (reset)
      query_xfer |=> v_ff[0])
      else $error("accepted query did not enter the pipeline");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      load_xfer |=> !v_ff[0])
      else $error("load transfer entered the result pipeline");

endmodule

// ===== test/tb_pairwise_euclidean_distance.sv =====
// Self-checking testbench for the pairwise Euclidean distance unit.
// Loads points, queries distances and checks every result against an in-bench predictor or a known table value.
// Depends on pwd_pkg and pairwise_euclidean_distance.
module tb_pairwise_euclidean_distance;
   timeunit 1ns;
   timeprecision 1ps;
   import pwd_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RSP_LATENCY   = 21;
   localparam int SETTLE_CYCLES = RSP_LATENCY + 4;
   localparam int TAIL_CYCLES   = RSP_LATENCY + 9;
   localparam int MAX_GAP       = 7;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 80;
   localparam int COORD_MAX     = 8388607;
   localparam int COORD_MIN     = -8388608;
   localparam int NODES         = DEF_MAX_NODES;

   // One row of the directed table: either a register write or an item.
   typedef struct {
      bit          is_csr;
      csr_idx_type csr_sel;
      int unsigned csr_value;
      req_type     item;
      bit          known;
      rsp_type     known_rsp;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor copy of the point store and the registers.
   coord_type        pt_x [NODES];
   coord_type        pt_y [NODES];
   coord_type        pt_z [NODES];
   bit               pt_loaded [NODES];
   int               loaded_ids [$];
   bit               use_z = 1'b0;
   logic [NC_W-1:0]  active_nodes = NC_W'(NODE_COUNT_RESET);

   rsp_type          pending_rsp [$];
   stim_row_type     stim_plan [$];
   int               mismatches = 0;
   int               rsp_hold = 0;
   bit               tx_calm = 1'b0;
   bit               rsp_calm = 1'b0;

   pairwise_euclidean_distance DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // Run limit, far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // Largest r with r*r <= v; v stays below 2^35 here.
   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 20; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // Expected result of a query, from the predictor's store and registers.
   function automatic rsp_type predict_distance(int a, int b);
      rsp_type         r;
      longint signed   dx;
      longint signed   dy;
      longint signed   dz;
      longint unsigned sq;
      r.distance    = '0;
      r.index_error = 1'b0;
      if (a >= active_nodes || b >= active_nodes) begin
         r.index_error = 1'b1;
         return r;
      end
      if (a == b) return r;
      dx = longint'(pt_x[a]) - longint'(pt_x[b]);
      dy = longint'(pt_y[a]) - longint'(pt_y[b]);
      dz = use_z ? longint'(pt_z[a]) - longint'(pt_z[b]) : 0;
      sq = dx * dx + dy * dy + dz * dz;
      // Drop the fraction bits of the sum of squares before the root.
      sq = sq >> (2 * FRAC_BITS);
      r.distance = DIST_W'(floor_root(sq));
      return r;
   endfunction

   // Coordinates lean on the extremes and on small values near zero.
   function automatic coord_type draw_coord();
      case ($urandom_range(0, 5))
         0: return coord_type'(COORD_MAX);
         1: return coord_type'(COORD_MIN);
         2: return coord_type'($urandom_range(0, 8191) - 4096);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic req_type load_req(int idx, int x, int y, int z);
      req_type r;
      r.cmd     = CMD_LOAD;
      r.point_a = PT_W'(idx);
      r.point_b = PT_W'($urandom_range(0, NODES - 1));
      r.x_coord = coord_type'(x);
      r.y_coord = coord_type'(y);
      r.z_coord = coord_type'(z);
      return r;
   endfunction

   // Query coordinates are unused, so they carry random bits.
   function automatic req_type query_req(int a, int b);
      req_type r;
      r.cmd     = CMD_QUERY;
      r.point_a = PT_W'(a);
      r.point_b = PT_W'(b);
      r.x_coord = draw_coord();
      r.y_coord = draw_coord();
      r.z_coord = draw_coord();
      return r;
   endfunction

   function automatic void add_csr(csr_idx_type sel, int unsigned value);
      stim_row_type row;
      row.is_csr    = 1'b1;
      row.csr_sel   = sel;
      row.csr_value = value;
      row.item      = '0;
      row.known     = 1'b0;
      row.known_rsp = '0;
      stim_plan.push_back(row);
   endfunction

   function automatic void add_item(req_type item, bit known = 1'b0, int want_dist = 0,
                                    bit err = 1'b0);
      stim_row_type row;
      row.is_csr                = 1'b0;
      row.csr_sel               = CSR_THREE_D;
      row.csr_value             = 0;
      row.item                  = item;
      row.known                 = known;
      row.known_rsp.distance    = DIST_W'(want_dist);
      row.known_rsp.index_error = err;
      stim_plan.push_back(row);
   endfunction

   // Picks a loaded point, mostly one inside the active range.
   function automatic int pick_point();
      int c;
      c = 0;
      for (int t = 0; t < 8; t++) begin
         c = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
         if (c < active_nodes || $urandom_range(0, 9) == 0) return c;
      end
      return c;
   endfunction

   // Presents one item after a random gap (none in calm phases) and records its effect
   // once the transfer has taken place. Valid stays high afterwards.
   task automatic send_item(req_type item, bit known, rsp_type known_rsp);
      int gap;
      int a;
      gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      a = int'(item.point_a);
      if (item.cmd == CMD_LOAD) begin
         pt_x[a] = item.x_coord;
         pt_y[a] = item.y_coord;
         pt_z[a] = item.z_coord;
         if (!pt_loaded[a]) loaded_ids.push_back(a);
         pt_loaded[a] = 1'b1;
      end else begin
         pending_rsp.push_back(known ? known_rsp
                                     : predict_distance(a, int'(item.point_b)));
      end
   endtask

   // Waits until the block has no work left, so a register may be written.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(csr_idx_type sel, int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_wdata <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      case (sel)
         CSR_THREE_D:    use_z = value[0];
         CSR_NODE_COUNT: active_nodes = value[NC_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result side: check each transfer, then stall for a random number of cycles, none in calm phases.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result distance %0d index_error %0b",
                     $time, rsp_data.distance, rsp_data.index_error);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.distance !== want.distance) begin
               $display("%0t: distance expected %0d actual %0d",
                        $time, want.distance, rsp_data.distance);
               mismatches++;
            end
            if (rsp_data.index_error !== want.index_error) begin
               $display("%0t: index_error expected %0b actual %0b",
                        $time, want.index_error, rsp_data.index_error);
               mismatches++;
            end
         end
         rsp_hold = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
      end else if (rsp_hold != 0) begin
         rsp_hold--;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= (rsp_hold != 0);
   end

   // Stimulus: directed table first, then random phases with new settings.
   initial begin
      req_type item;
      int      a;
      int      b;
      int      nc;

      // Directed table. Point 1 sits at (3, 4, 12) units from the origin.
      add_item(load_req(0, 0, 0, 0));
      add_item(load_req(1, 768, 1024, 3072));
      add_item(load_req(2, 511, 0, 0));
      add_item(load_req(3, -768, -1024, 0));
      add_item(load_req(1023, COORD_MIN, COORD_MIN, COORD_MIN));
      add_item(load_req(1022, COORD_MAX, COORD_MAX, COORD_MAX));
      add_item(query_req(0, 1), 1'b1, 5);
      add_item(query_req(1, 0), 1'b1, 5);
      // Just under two units: the fraction is dropped.
      add_item(query_req(0, 2), 1'b1, 1);
      add_item(query_req(1, 3), 1'b1, 10);
      add_item(query_req(1, 1), 1'b1, 0);
      add_item(query_req(1023, 1022), 1'b1, 92681);
      add_csr(CSR_THREE_D, 1);
      add_item(query_req(0, 1), 1'b1, 13);
      add_item(query_req(1022, 1023), 1'b1, 113511);
      add_item(query_req(1023, 0));
      add_item(query_req(1, 3));
      add_csr(CSR_NODE_COUNT, 1023);
      add_item(query_req(1023, 0), 1'b1, 0, 1'b1);
      add_item(query_req(0, 1022));
      // A load above the active range is still written.
      add_item(load_req(1023, 256, -256, 0));
      add_csr(CSR_NODE_COUNT, 1024);
      add_item(query_req(1023, 0));
      add_csr(CSR_NODE_COUNT, 1);
      add_item(query_req(0, 0), 1'b1, 0);
      add_item(query_req(0, 1), 1'b1, 0, 1'b1);
      add_csr(CSR_NODE_COUNT, 0);
      add_item(query_req(0, 0), 1'b1, 0, 1'b1);
      add_csr(CSR_NODE_COUNT, 1024);
      add_csr(CSR_THREE_D, 0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_plan[i]) begin
         if (stim_plan[i].is_csr) begin
            settle();
            csr_write(stim_plan[i].csr_sel, stim_plan[i].csr_value);
         end else begin
            send_item(stim_plan[i].item, stim_plan[i].known, stim_plan[i].known_rsp);
         end
      end

      // Random phases; each starts from an idle block with fresh settings.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case ($urandom_range(0, 5))
            0: nc = 1;
            1: nc = 2;
            2: nc = 1023;
            3: nc = 1024;
            4: nc = $urandom_range(1, 64);
            default: nc = $urandom_range(1, 1024);
         endcase
         csr_write(CSR_THREE_D, phase % 2);
         csr_write(CSR_NODE_COUNT, nc);
         tx_calm  = (phase % 3 == 1);
         rsp_calm = (phase % 4 == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 35) begin
               // At least half the loads land in the active range so queries can reach them.
               if ($urandom_range(0, 1) == 0 || active_nodes == 0)
                  a = $urandom_range(0, NODES - 1);
               else
                  a = $urandom_range(0, active_nodes - 1);
               item = load_req(a, draw_coord(), draw_coord(), draw_coord());
            end else begin
               a = pick_point();
               b = ($urandom_range(0, 9) == 0) ? a : pick_point();
               item = query_req(a, b);
            end
            send_item(item, 1'b0, '0);
         end
      end

      // Drain and report.
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/pwd_pkg.sv
sv/pwd_store.sv
sv/pwd_sqsum.sv
sv/pwd_isqrt.sv
sv/pwd_rspq.sv
sv/pairwise_euclidean_distance.sv
test/tb_pairwise_euclidean_distance.sv
